[hdl/lrast_pkg.sv]
`timescale 1ns / 1ps
package lrast_pkg;
	localparam int Leaves = 1024;
	localparam int Levels = $clog2(Leaves);
	localparam int LvlBits = $clog2(Levels + 1);
	localparam int NodeCount = 2 * Leaves - 1;
	localparam int NodeBits = $clog2(NodeCount);
	localparam int ValueWidth = 32;
	localparam int IdxWidth = 11;
	localparam int OpWidth = 2;
	localparam int AddrWidth = 2;

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [NodeBits-1:0] node_t;
	typedef logic [IdxWidth-1:0] idx_t;

	typedef enum logic [OpWidth-1:0] {
		OP_QUERY  = 2'd0,
		OP_ADD    = 2'd1,
		OP_ASSIGN = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [AddrWidth-1:0] REG_ELEMENTS_IN_USE = 2'd0;

	// one node record: flag, pending, sum
	typedef struct packed {
		logic   flag;
		value_t pending;
		value_t sum;
	} node_rec_t;
	localparam int RecWidth = $bits(node_rec_t);
endpackage

[hdl/lrast_if.sv]
`timescale 1ns / 1ps
interface lrast_req_if;
	logic                   valid;
	logic                   ready;
	logic [1:0]             operation;
	logic [10:0]            range_start;
	logic [10:0]            range_end;
	logic signed [31:0]     operand_value;
	modport source (output valid, operation, range_start, range_end, operand_value, input ready);
	modport sink (input valid, operation, range_start, range_end, operand_value, output ready);
endinterface

interface lrast_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] range_sum;
	logic               range_error;
	modport source (output valid, range_sum, range_error, input ready);
	modport sink (input valid, range_sum, range_error, output ready);
endinterface

[hdl/lrast_ram.sv]
`timescale 1ns / 1ps
module lrast_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/lazy_range_add_assign_sum_tree_core.sv]
`timescale 1ns / 1ps
// Errors and unknown operations skip the tree walk; other words visit nodes,
// each visited node being disjoint, covered or split.
// Throughput: one word at a time; the next word is taken once the tree walk ends
// and its result has entered the output register, where it may still wait.
// Reset: node memory cleared one node a cycle, all 2047 nodes, before the first
// word is taken; elements_in_use resets to 1024.
module lazy_range_add_assign_sum_tree_core (
	input  logic         clk,
	input  logic         arst_n,
	lrast_req_if.sink    req,
	lrast_rsp_if.source  rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import lrast_pkg::*;

	// Iterative DFS using an explicit stack, entries hold
	// node, lo, width-log, phase.
	typedef enum logic [10:0] {
		S_CLEAR  = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_VISIT  = 11'b00000000100,
		S_RDN    = 11'b00000001000,
		S_RDA    = 11'b00000010000,
		S_RDB    = 11'b00000100000,
		S_WRB    = 11'b00001000000,
		S_WRN    = 11'b00010000000,
		S_PLA    = 11'b00100000000,
		S_PLB    = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	typedef struct packed {
		node_t             node;
		idx_t              lo;
		logic [LvlBits-1:0] lvl;   // width = 2^lvl
		logic [1:0]        phase;  // 0 enter, 1 after left, 2 after right
	} frame_t;

	state_t state_q;
	idx_t eiu_q;
	node_t clr_q;
	frame_t stk_q [Levels+1];
	logic [LvlBits-1:0] sp_q;
	op_t op_q;
	idx_t l_q, r_q;
	value_t v_q, acc_q;
	logic err_q;
	node_rec_t n_q, a_q, b_q;

	logic we;
	node_t waddr, raddr;
	node_rec_t wdata, rdata;

	lrast_ram #(.Width(RecWidth), .Depth(NodeCount)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	function automatic node_rec_t push_child(node_rec_t p, node_rec_t c);
		node_rec_t o;
		o = c;
		if (p.flag) begin
			o.flag = 1'b1;
			o.pending = p.pending;
		end else begin
			o.pending = c.pending + p.pending;
		end
		return o;
	endfunction

	frame_t top;
	idx_t hi, mid, wid, half, limit;
	node_t ca, cb;
	value_t nval, aval, bval;
	node_rec_t upd;
	logic covered, disjoint, pop;
	logic [LvlBits-1:0] spm;

	always_comb begin
		top = stk_q[sp_q];
		wid = idx_t'(1) << top.lvl;
		half = wid >> 1;
		hi = top.lo + wid;
		mid = top.lo + half;
		ca = node_t'(2 * top.node + 1);
		cb = node_t'(2 * top.node + 2);
		covered = (top.lo >= l_q) && (hi <= r_q);
		disjoint = (top.lo >= r_q) || (hi <= l_q);
		nval = (rdata.flag ? '0 : rdata.sum) + (rdata.pending << top.lvl);
		aval = (a_q.flag ? '0 : a_q.sum) + (a_q.pending << (top.lvl - 1'b1));
		bval = (rdata.flag ? '0 : rdata.sum) + (rdata.pending << (top.lvl - 1'b1));
		upd = rdata;
		if (op_q == OP_ASSIGN) begin
			upd.flag = 1'b1;
			upd.pending = v_q;
		end else begin
			upd.pending = rdata.pending + v_q;
		end
		limit = (eiu_q > idx_t'(Leaves)) ? idx_t'(Leaves) : eiu_q;
		spm = sp_q - 1'b1;
		pop = (state_q == S_VISIT && top.phase == 2'd0 && disjoint) ||
			(state_q == S_RDN && covered) || (state_q == S_PLB);
	end

	assign req.ready = (state_q == S_IDLE);
	assign pready = 1'b1;
	assign prdata = (paddr == REG_ELEMENTS_IN_USE) ? 32'(eiu_q) : '0;

	always_comb begin
		we = 1'b0;
		waddr = top.node;
		wdata = n_q;
		raddr = top.node;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_VISIT: raddr = (top.phase == 2'd2) ? ca : top.node;
			S_RDN: begin
				if (covered) begin
					we = (op_q != OP_QUERY);
					wdata = upd;
				end else begin
					raddr = ca;
				end
			end
			S_RDA: raddr = cb;
			S_RDB: begin
				we = 1'b1;
				waddr = ca;
				wdata = push_child(n_q, a_q);
			end
			S_WRB: begin
				we = 1'b1;
				waddr = cb;
				wdata = b_q;
			end
			S_WRN: begin
				we = 1'b1;
				wdata = '{flag: 1'b0, pending: '0, sum: n_q.sum};
			end
			S_PLA: raddr = cb;
			S_PLB: begin
				we = 1'b1;
				wdata = '{flag: 1'b0, pending: '0, sum: aval + bval};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			eiu_q <= idx_t'(Leaves);
			sp_q <= '0;
			stk_q <= '{default: '0};
			op_q <= OP_QUERY;
			l_q <= '0;
			r_q <= '0;
			v_q <= '0;
			acc_q <= '0;
			err_q <= 1'b0;
			n_q <= '0;
			a_q <= '0;
			b_q <= '0;
			rsp.valid <= 1'b0;
			rsp.range_sum <= '0;
			rsp.range_error <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_ELEMENTS_IN_USE) begin
				eiu_q <= pwdata[IdxWidth-1:0];
			end
			if (state_q == S_DONE && (!rsp.valid || rsp.ready)) begin
				rsp.valid <= 1'b1;
				rsp.range_sum <= (op_q == OP_QUERY && !err_q) ? acc_q : '0;
				rsp.range_error <= err_q;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == node_t'(NodeCount - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						op_q <= op_t'(req.operation);
						l_q <= req.range_start;
						r_q <= req.range_end;
						v_q <= value_t'(req.operand_value);
						acc_q <= '0;
						err_q <= 1'b0;
						if (req.operation == OP_NONE) begin
							state_q <= S_DONE;
						end else if (req.range_end > limit ||
								req.range_start >= req.range_end) begin
							err_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							stk_q[0] <= '{node: '0, lo: '0, lvl: LvlBits'(Levels), phase: 2'd0};
							sp_q <= '0;
							state_q <= S_VISIT;
						end
					end
				end
				S_VISIT: begin
					if (top.phase == 2'd0) begin
						if (!disjoint) begin
							state_q <= S_RDN;
						end
					end else if (top.phase == 2'd1) begin
						stk_q[sp_q + 1'b1] <= '{node: cb, lo: mid,
							lvl: top.lvl - 1'b1, phase: 2'd0};
						sp_q <= sp_q + 1'b1;
					end else begin
						state_q <= S_PLA;
					end
				end
				S_RDN: begin
					if (covered) begin
						if (op_q == OP_QUERY) begin
							acc_q <= acc_q + nval;
						end
					end else begin
						n_q <= rdata;
						state_q <= S_RDA;
					end
				end
				S_RDA: begin
					a_q <= rdata;
					state_q <= S_RDB;
				end
				S_RDB: begin
					b_q <= push_child(n_q, rdata);
					state_q <= S_WRB;
				end
				S_WRB: state_q <= S_WRN;
				S_WRN: begin
					stk_q[sp_q + 1'b1] <= '{node: ca, lo: top.lo,
						lvl: top.lvl - 1'b1, phase: 2'd0};
					sp_q <= sp_q + 1'b1;
					state_q <= S_VISIT;
				end
				S_PLA: begin
					a_q <= rdata;
					state_q <= S_PLB;
				end
				S_PLB: ;
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (pop) begin
				if (sp_q == '0) begin
					state_q <= S_DONE;
				end else begin
					sp_q <= spm;
					stk_q[spm].phase <= stk_q[spm].phase + 1'b1;
					state_q <= S_VISIT;
				end
			end
		end
	end
endmodule
